>>> rtl/core/swmm_pkg.sv
// Shared constants and codes for the sliding window min/max/mean unit.
`default_nettype none

package swmm_pkg;

  // Default number of sample slots in the store.
  localparam int unsigned DEFAULT_WINDOW_DEPTH = 256;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned CAP_W    = 9;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Request action codes.
  localparam logic ACTION_ADD   = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/sliding_window_min_max_mean_unit.sv
// Top level of the sliding window min/max/mean unit: control, store update and scan.
//
//   Port group   Direction  Handshake        Contents
//   in_*         input      in_valid/stall   action, sample value, overwrite flag
//   out_*        output     out_valid/stall  count, min, max, mean, overflow
//   cfg_*        input      cfg_valid/ready  window capacity
//
// The store is read once per cycle for min, max and sum over the held samples, then the
// divider produces one quotient bit per cycle for SUM_W bits (41 at depth 256); an empty
// store skips the divider. in_stall drops as out_valid rises.
// Reset clears the count and write pointer and sets the capacity to its full value; the
// store itself is not cleared. A finished result waits in the output register, so the
// next request may be accepted while out_stall holds the previous one.
`default_nettype none

module sliding_window_min_max_mean_unit #(
  parameter int unsigned WINDOW_DEPTH = swmm_pkg::DEFAULT_WINDOW_DEPTH,
  localparam int unsigned AW  = $clog2(WINDOW_DEPTH),
  localparam int unsigned CW  = $clog2(WINDOW_DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_action,
  input  wire logic signed [31:0]          in_sample_value,
  input  wire logic                        in_overwrite_when_full,

  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic             [CW-1:0]        out_sample_count,
  output logic signed      [31:0]          out_window_min,
  output logic signed      [31:0]          out_window_max,
  output logic signed      [31:0]          out_window_mean,
  output logic                             out_overflow,

  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [swmm_pkg::CAP_W-1:0]  cfg_window_capacity
);

  localparam int unsigned SW = swmm_pkg::SAMPLE_W;
  localparam int unsigned SUM_W = SW + CW;
  localparam int unsigned EW = (CW > swmm_pkg::CAP_W) ? CW : swmm_pkg::CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_DONE
  } state_t;

  state_t                      state_r;
  logic [swmm_pkg::CAP_W-1:0]  cap_r;
  logic [CW-1:0]               held_r;
  logic [AW-1:0]               wp_r;
  logic                        ovf_r;
  logic [CW-1:0]               idx_r;
  logic                        rd_pend_r;
  logic                        first_r;
  logic signed [SW-1:0]        lo_r;
  logic signed [SW-1:0]        hi_r;
  logic signed [SUM_W-1:0]     sum_r;
  logic signed [SW-1:0]        mean_r;
  logic                        out_valid_r;
  logic [CW-1:0]               out_count_r;
  logic signed [SW-1:0]        out_min_r;
  logic signed [SW-1:0]        out_max_r;
  logic signed [SW-1:0]        out_mean_r;
  logic                        out_ovf_r;

  logic                        accept;
  logic [EW-1:0]               cap_ext;
  logic [EW-1:0]               cap_lim;
  logic [CW-1:0]               eff_cap;
  logic [CW-1:0]               held_nxt;
  logic [AW-1:0]               wp_nxt;
  logic [AW-1:0]               wp_use;
  logic [CW-1:0]               wp_inc;
  logic                        ovf_nxt;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic                        rd_issue;
  logic [SW-1:0]               rd_data;
  logic signed [SW-1:0]        rd_val;
  logic                        scan_end;
  logic                        div_start;
  logic                        div_done;
  logic [SUM_W-1:0]            sum_mag;
  logic [SUM_W-1:0]            quot;
  logic signed [SW-1:0]        quot_s;
  logic                        load_out;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Effective capacity: zero acts as one, anything above the depth acts as the depth.
  always_comb begin
    cap_ext = EW'(cap_r);
    if (cap_ext == '0) begin
      cap_lim = EW'(1);
    end else if (cap_ext > EW'(WINDOW_DEPTH)) begin
      cap_lim = EW'(WINDOW_DEPTH);
    end else begin
      cap_lim = cap_ext;
    end
    eff_cap = CW'(cap_lim);
  end

  // Store update for an accepted request: append, overwrite, drop or clear.
  always_comb begin
    held_nxt = held_r;
    wp_nxt   = wp_r;
    ovf_nxt  = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = held_r[AW-1:0];
    wp_use   = (CW'(wp_r) >= eff_cap) ? '0 : wp_r;
    wp_inc   = CW'(wp_use) + 1'b1;
    if (in_action == swmm_pkg::ACTION_CLEAR) begin
      held_nxt = '0;
    end else if (held_r < eff_cap) begin
      wr_en    = accept;
      held_nxt = held_r + 1'b1;
    end else if (in_overwrite_when_full) begin
      wr_en    = accept;
      wr_addr  = wp_use;
      wp_nxt   = (wp_inc >= eff_cap) ? '0 : wp_inc[AW-1:0];
    end else begin
      ovf_nxt  = 1'b1;
    end
  end

  // Scan control: issue one read per cycle, finish once the last read has returned.
  assign rd_issue = (state_r == S_SCAN) && (idx_r < held_r);
  assign scan_end = (state_r == S_SCAN) && !rd_issue && !rd_pend_r;
  assign rd_val   = $signed(rd_data);

  // Divider operands: magnitude of the sum over the held count.
  assign div_start = scan_end && (held_r != '0);
  assign sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign quot_s    = $signed(quot[SW-1:0]);

  // The output register takes a result when it is empty or being drained.
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  swmm_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_sample_value),
    .rd_en   (rd_issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  swmm_div #(
    .DVD_W (SUM_W),
    .DVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (held_r),
    .done     (div_done),
    .quotient (quot)
  );

  // Sequencer, statistics accumulators and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= swmm_pkg::CAP_RESET;
      held_r      <= '0;
      wp_r        <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_window_capacity;
      end

      if (out_valid_r && !out_stall && !load_out) begin
        out_valid_r <= 1'b0;
      end

      rd_pend_r <= rd_issue;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            held_r  <= held_nxt;
            wp_r    <= wp_nxt;
            ovf_r   <= ovf_nxt;
            idx_r   <= '0;
            first_r <= 1'b1;
            lo_r    <= '0;
            hi_r    <= '0;
            sum_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_issue) begin
            idx_r <= idx_r + 1'b1;
          end
          // Fold in the sample that the memory returned this cycle.
          if (rd_pend_r) begin
            first_r <= 1'b0;
            sum_r   <= sum_r + SUM_W'(rd_val);
            if (first_r || rd_val < lo_r) begin
              lo_r <= rd_val;
            end
            if (first_r || rd_val > hi_r) begin
              hi_r <= rd_val;
            end
          end
          if (scan_end) begin
            mean_r  <= '0;
            state_r <= (held_r != '0) ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mean_r  <= sum_r[SUM_W-1] ? -quot_s : quot_s;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            out_count_r <= held_r;
            out_min_r   <= lo_r;
            out_max_r   <= hi_r;
            out_mean_r  <= mean_r;
            out_ovf_r   <= ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_count = out_count_r;
  assign out_window_min   = out_min_r;
  assign out_window_max   = out_max_r;
  assign out_window_mean  = out_mean_r;
  assign out_overflow     = out_ovf_r;

endmodule

`default_nettype wire

>>> rtl/core/swmm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module swmm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/swmm_div.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none

module swmm_div #(
  parameter int unsigned DVD_W = 41,
  parameter int unsigned DVS_W = 9,
  localparam int unsigned STEP_W = $clog2(DVD_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0]  dq_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0]    rem_shift;
  logic [DVS_W:0]    rem_diff;
  logic              q_bit;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    rem_shift = {rem_r, dq_r[DVD_W-1]};
    rem_diff  = rem_shift - {1'b0, dvs_r};
    q_bit     = (rem_shift >= {1'b0, dvs_r});
  end

  // Iteration control and the combined dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        step_r <= '0;
        dq_r   <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        dq_r   <= {dq_r[DVD_W-2:0], q_bit};
        rem_r  <= q_bit ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        done_r <= (step_r == STEP_W'(DVD_W - 1));
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
        end
        step_r <= step_r + 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

`default_nettype wire

>>> sim/sliding_window_min_max_mean_unit_tb.sv
// Self-checking testbench for the sliding window min/max/mean unit.
`default_nettype none

module sliding_window_min_max_mean_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = swmm_pkg::SAMPLE_W;
  localparam int CAP_W        = swmm_pkg::CAP_W;
  localparam int WINDOW_SLOTS = swmm_pkg::DEFAULT_WINDOW_DEPTH;
  localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);
  localparam int MAX_WAIT     = 17;

  // One request as the sender presents it.
  typedef struct {
    logic                     action;
    logic signed [SAMPLE_W-1:0] sample;
    logic                     overwrite;
  } window_request_t;

  // Statistics reported for one request.
  typedef struct {
    logic        [CNT_W-1:0]    count;
    logic signed [SAMPLE_W-1:0] min_val;
    logic signed [SAMPLE_W-1:0] max_val;
    logic signed [SAMPLE_W-1:0] mean_val;
    logic                       overflow;
  } window_stats_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_action = swmm_pkg::ACTION_ADD;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic                       in_overwrite_when_full = 1'b0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic        [CNT_W-1:0]    out_sample_count;
  logic signed [SAMPLE_W-1:0] out_window_min;
  logic signed [SAMPLE_W-1:0] out_window_max;
  logic signed [SAMPLE_W-1:0] out_window_mean;
  logic                       out_overflow;

  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic        [CAP_W-1:0]    cfg_window_capacity = swmm_pkg::CAP_RESET;

  sliding_window_min_max_mean_unit dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_sample_value        (in_sample_value),
    .in_overwrite_when_full (in_overwrite_when_full),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_sample_count       (out_sample_count),
    .out_window_min         (out_window_min),
    .out_window_max         (out_window_max),
    .out_window_mean        (out_window_mean),
    .out_overflow           (out_overflow),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_window_capacity    (cfg_window_capacity)
  );

  // Shadow copy of the block's state, used to predict each result.
  logic signed [SAMPLE_W-1:0] window_store [WINDOW_SLOTS];
  int                         held_samples = 0;
  int                         write_slot = 0;
  logic        [CAP_W-1:0]    capacity_setting = swmm_pkg::CAP_RESET;

  window_request_t pending_requests[$];
  window_stats_t   expected_stats[$];
  int              queued_total = 0;
  int              accepted_total = 0;
  bit              quiet_phase = 1'b0;
  bit              failed = 1'b0;
  int              send_wait = 0;
  int              stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one request to the shadow state and queues the statistics it must produce.
  function automatic void predict_window(input logic action,
                                         input logic signed [SAMPLE_W-1:0] value,
                                         input logic overwrite);
    window_stats_t stats;
    int            cap;
    longint        total;
    cap = (capacity_setting == 0) ? 1 :
          (capacity_setting > WINDOW_SLOTS) ? WINDOW_SLOTS : int'(capacity_setting);
    stats.overflow = 1'b0;
    if (action == swmm_pkg::ACTION_CLEAR) begin
      held_samples = 0;
    end else if (held_samples < cap) begin
      window_store[held_samples] = value;
      held_samples++;
    end else if (overwrite) begin
      // A pointer left beyond a lowered capacity wraps before the write.
      if (write_slot >= cap) write_slot = 0;
      window_store[write_slot] = value;
      write_slot++;
      if (write_slot >= cap) write_slot = 0;
    end else begin
      stats.overflow = 1'b1;
    end
    stats.count   = held_samples[CNT_W-1:0];
    stats.min_val = '0;
    stats.max_val = '0;
    total = 0;
    for (int i = 0; i < held_samples; i++) begin
      if (i == 0 || window_store[i] < stats.min_val) stats.min_val = window_store[i];
      if (i == 0 || window_store[i] > stats.max_val) stats.max_val = window_store[i];
      total += longint'(window_store[i]);
    end
    // Signed division truncates toward zero, as the block does.
    stats.mean_val = (held_samples > 0) ? SAMPLE_W'(total / held_samples) : '0;
    expected_stats.insert(expected_stats.size(), stats);
  endfunction

  function automatic int draw_wait();
    return quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void report_mismatch(input string field,
                                          input logic signed [SAMPLE_W-1:0] want,
                                          input logic signed [SAMPLE_W-1:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    failed = 1'b1;
  endfunction

  // Sender: presents queued requests with random gaps and predicts each accepted one.
  always @(posedge clk) begin
    window_request_t req;
    logic            busy;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        predict_window(in_action, in_sample_value, in_overwrite_when_full);
        accepted_total++;
        busy = 1'b0;
        send_wait = draw_wait();
      end
      if (!busy) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_requests.size() > 0) begin
          req = pending_requests.pop_front();
          in_action              <= req.action;
          in_sample_value        <= req.sample;
          in_overwrite_when_full <= req.overwrite;
          busy = 1'b1;
        end
      end
      in_valid <= busy;
    end
  end

  // Receiver: stalls at random and checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    window_stats_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result, count %0d min %0d max %0d mean %0d overflow %0b",
                 $time, out_sample_count, out_window_min, out_window_max, out_window_mean,
                 out_overflow);
        failed = 1'b1;
      end else begin
        want = expected_stats.pop_front();
        if (out_sample_count !== want.count)
          report_mismatch("sample_count", want.count, out_sample_count);
        if (out_window_min !== want.min_val)
          report_mismatch("window_min", want.min_val, out_window_min);
        if (out_window_max !== want.max_val)
          report_mismatch("window_max", want.max_val, out_window_max);
        if (out_window_mean !== want.mean_val)
          report_mismatch("window_mean", want.mean_val, out_window_mean);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", want.overflow, out_overflow);
      end
      stall_left = draw_wait();
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  task automatic queue_request(input logic action, input logic [SAMPLE_W-1:0] value,
                               input logic overwrite);
    window_request_t req;
    req.action    = action;
    req.sample    = value;
    req.overwrite = overwrite;
    pending_requests.insert(pending_requests.size(), req);
    queued_total++;
  endtask

  // Returns at a clock edge once every queued request has been answered.
  task automatic wait_drained();
    while (!(accepted_total == queued_total && expected_stats.size() == 0))
      @(posedge clk);
  endtask

  // Capacity writes happen only while the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_valid           <= 1'b1;
    cfg_window_capacity <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_setting = value;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return SAMPLE_W'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: reset, directed corner cases, then random phases at several capacities.
  initial begin
    int cap_pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset capacity: empty clear, full-scale extremes, negative mean truncation.
    queue_request(swmm_pkg::ACTION_CLEAR, 32'h1234_5678, 1'b1);
    queue_request(swmm_pkg::ACTION_ADD, 32'h7FFF_FFFF, 1'b0);
    queue_request(swmm_pkg::ACTION_ADD, 32'h8000_0000, 1'b1);
    queue_request(swmm_pkg::ACTION_ADD, 32'h0000_0000, 1'b0);
    queue_request(swmm_pkg::ACTION_ADD, 32'hFFFF_FFFF, 1'b0);
    queue_request(swmm_pkg::ACTION_CLEAR, 32'hFFFF_FFFF, 1'b0);
    queue_request(swmm_pkg::ACTION_ADD, 32'hFFFF_FFFE, 1'b0);

    // Capacity zero behaves as one: drop, then overwrite slot zero.
    write_capacity(9'd0);
    queue_request(swmm_pkg::ACTION_ADD, 32'h0001_0000, 1'b0);
    queue_request(swmm_pkg::ACTION_ADD, 32'hFFFF_0000, 1'b1);

    // Fill four slots and overwrite three, leaving the pointer at three.
    write_capacity(9'd4);
    queue_request(swmm_pkg::ACTION_CLEAR, 32'h0, 1'b0);
    queue_request(swmm_pkg::ACTION_ADD, 32'h0000_0003, 1'b0);
    queue_request(swmm_pkg::ACTION_ADD, 32'hFFFF_FFF9, 1'b0);
    queue_request(swmm_pkg::ACTION_ADD, 32'h0000_0002, 1'b1);
    queue_request(swmm_pkg::ACTION_ADD, 32'h0000_0005, 1'b0);
    queue_request(swmm_pkg::ACTION_ADD, 32'h7FFF_FFFF, 1'b1);
    queue_request(swmm_pkg::ACTION_ADD, 32'h7FFF_FFFF, 1'b1);
    queue_request(swmm_pkg::ACTION_ADD, 32'h8000_0000, 1'b1);

    // Capacity below the held count: pointer wraps, plain adds are dropped.
    write_capacity(9'd2);
    queue_request(swmm_pkg::ACTION_ADD, 32'h0000_0010, 1'b1);
    queue_request(swmm_pkg::ACTION_ADD, 32'h0000_0011, 1'b0);

    // Capacity above the store depth behaves as the full depth.
    write_capacity(9'd511);
    queue_request(swmm_pkg::ACTION_ADD, 32'hDEAD_BEEF, 1'b0);
    queue_request(swmm_pkg::ACTION_ADD, 32'h2152_4110, 1'b1);

    // Random phases: mostly small capacities so the store fills and wraps often.
    for (int phase = 0; phase < 14; phase++) begin
      if (phase == 0) cap_pick = 256;
      else if (phase == 1) cap_pick = 257;
      else if (phase == 2) cap_pick = 1;
      else if ($urandom_range(0, 4) == 0) cap_pick = $urandom_range(13, 511);
      else cap_pick = $urandom_range(0, 12);
      write_capacity(CAP_W'(cap_pick));
      quiet_phase = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 28; k++) begin
        if ($urandom_range(0, 99) < 6)
          queue_request(swmm_pkg::ACTION_CLEAR, $urandom, 1'($urandom));
        else
          queue_request(swmm_pkg::ACTION_ADD, random_sample(), ($urandom_range(0, 9) < 7));
      end
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
